// ===== rtl/hsla_pkg.sv =====
// Shared types and constants for the HSLA modulation to RGB block.
// Holds field widths, register indexes, multiplier operation codes and the
// controller-to-datapath command record. No dependencies.
package hsla_pkg;

   localparam int VOLTS_W    = 17;
   localparam int CHANNELS   = 4;
   localparam int KNOB_W     = 17;
   localparam int MASK_W     = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;
   localparam int REQ_DATA_W = ((CHANNELS * VOLTS_W + 7) / 8) * 8;
   localparam int OUT_FIELDS = 7;

   // Voltage after the optional 5 V offset needs one more bit than the field.
   localparam int VADJ_W     = VOLTS_W + 1;
   // Ten volts is 40960 = 5 * 2^13 in 1/4096 V units.
   localparam int DIV_SHIFT  = 13;
   localparam int DIV_ODD    = 5;
   localparam int FIVE_VOLTS = 20480;

   localparam logic [CSR_IDX_W-1:0] CSR_HUE_KNOB   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SAT_KNOB   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LIGHT_KNOB = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_KNOB = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CONNECTED  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CHAINED    = 3'd5;

   localparam logic [1:0] CH_HUE   = 2'd0;
   localparam logic [1:0] CH_SAT   = 2'd1;
   localparam logic [1:0] CH_LIGHT = 2'd2;
   localparam logic [1:0] CH_ALPHA = 2'd3;

   localparam logic [1:0] MUL_NONE  = 2'd0;
   localparam logic [1:0] MUL_TENTH = 2'd1;
   localparam logic [1:0] MUL_LS    = 2'd2;
   localparam logic [1:0] MUL_RAMP  = 2'd3;

   typedef struct packed {
      logic       load;
      logic [1:0] mul_op;
      logic [1:0] mul_idx;
      logic       fix_en;
      logic [1:0] fix_idx;
      logic       mix_en;
      logic       ramp_en;
      logic [1:0] ramp_idx;
      logic       out_load;
   } hsla_cmd_type;

endpackage

// ===== rtl/hsla_ctrl.sv =====
// Sequencing controller for the HSLA modulation to RGB block.
// Steps one transaction through channel, mix and color phases and owns the
// result valid flag. Depends on hsla_pkg.
module hsla_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output hsla_pkg::hsla_cmd_type cmd
);
   import hsla_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CHAN  = 3'd1;
   localparam logic [2:0] ST_MIX   = 3'd2;
   localparam logic [2:0] ST_COLOR = 3'd3;
   localparam logic [2:0] ST_FLUSH = 3'd4;

   localparam logic [2:0] CHAN_LAST  = 3'd4;
   localparam logic [2:0] COLOR_LAST = 3'd3;

   logic [2:0] state_ff, state_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_CHAN;
               cnt_in   = 3'd0;
            end
         end
         ST_CHAN: begin
            // Divide for channel cnt while the previous channel is finished.
            if (cnt_ff != CHAN_LAST) begin
               cmd.mul_op  = MUL_TENTH;
               cmd.mul_idx = cnt_ff[1:0];
            end else begin
               cmd.mul_op = MUL_LS;
            end
            if (cnt_ff != 3'd0) begin
               cmd.fix_en  = 1'b1;
               cmd.fix_idx = 2'(cnt_ff - 3'd1);
            end
            if (cnt_ff == CHAN_LAST) begin
               state_in = ST_MIX;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         ST_MIX: begin
            cmd.mix_en = 1'b1;
            state_in   = ST_COLOR;
            cnt_in     = 3'd0;
         end
         ST_COLOR: begin
            if (cnt_ff != COLOR_LAST) begin
               cmd.mul_op  = MUL_RAMP;
               cmd.mul_idx = cnt_ff[1:0];
            end
            if (cnt_ff != 3'd0) begin
               cmd.ramp_en  = 1'b1;
               cmd.ramp_idx = 2'(cnt_ff - 3'd1);
            end
            if (cnt_ff == COLOR_LAST) begin
               state_in = ST_FLUSH;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         ST_FLUSH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == ST_CHAN && cnt_ff == 3'd0)
      else $error("accepted transaction did not start the channel pass");

   a_valid_from_flush: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff) == ST_FLUSH)
      else $error("result valid rose outside the flush step");

   a_load_returns_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_tvalid && state_ff == ST_IDLE)
      else $error("result load did not present the result and return to idle");

endmodule

// ===== rtl/hsla_dpath.sv =====
// Datapath for the HSLA modulation to RGB block: configuration registers,
// unipolar flags, one shared multiplier, channel, mix and ramp arithmetic and
// the result register. Driven by hsla_ctrl commands. Depends on hsla_pkg.
module hsla_dpath #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  hsla_pkg::hsla_cmd_type              cmd,
   input  logic [hsla_pkg::REQ_DATA_W-1:0]     req_data,
   input  logic                                csr_wr_en,
   input  logic [hsla_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [hsla_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic [((hsla_pkg::OUT_FIELDS * (FRAC_BITS + 1) + 7) / 8) * 8 - 1:0] rsp_data
);
   import hsla_pkg::*;

   localparam int OW    = FRAC_BITS + 1;
   localparam int KW    = (OW > KNOB_W) ? OW : KNOB_W;
   localparam int NW    = VADJ_W + FRAC_BITS + 1;
   localparam int MW    = NW - DIV_SHIFT;
   localparam int XW    = MW + 2;
   localparam int PRW   = 2 * XW;
   localparam int SW    = XW + 1;
   localparam int PW    = FRAC_BITS + 3;
   localparam int RSP_W = ((OUT_FIELDS * OW + 7) / 8) * 8;

   localparam logic [OW-1:0]        ONE    = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [OW-1:0]        HALF   = ONE >> 1;
   localparam logic signed [SW-1:0] ONE_S  = SW'(ONE);
   localparam logic [XW-1:0]        RECIP  = XW'((64'd1 << XW) / 64'd5);
   localparam logic [XW-1:0]        BIAS   = XW'(64'd5 << (MW - 1));
   localparam logic [XW-1:0]        QBIAS  = XW'(64'd1 << (MW - 1));
   localparam logic [PW-1:0]        ONE_P   = PW'(ONE);
   localparam logic [PW-1:0]        TWO_P   = PW'(2) << FRAC_BITS;
   localparam logic [PW-1:0]        THREE_P = PW'(3) << FRAC_BITS;
   localparam logic [PW-1:0]        FOUR_P  = PW'(4) << FRAC_BITS;
   localparam logic [PW-1:0]        SIX_P   = PW'(6) << FRAC_BITS;
   localparam logic signed [VOLTS_W-1:0] FIVE_V = VOLTS_W'(FIVE_VOLTS);

   localparam logic [1:0] KIND_RAMP = 2'd0;
   localparam logic [1:0] KIND_HIGH = 2'd1;
   localparam logic [1:0] KIND_LOW  = 2'd2;

   function automatic logic [OW-1:0] clamp_one(input logic signed [SW-1:0] v);
      logic [OW-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > ONE_S) begin
         r = ONE;
      end else begin
         r = v[OW-1:0];
      end
      return r;
   endfunction

   // Configuration registers.
   logic [KW-1:0]     knob_ff [CHANNELS];
   logic [MASK_W-1:0] connected_ff;
   logic [MASK_W-1:0] chained_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         knob_ff[CH_HUE]   <= '0;
         knob_ff[CH_SAT]   <= '0;
         knob_ff[CH_LIGHT] <= '0;
         knob_ff[CH_ALPHA] <= KW'(ONE);
         connected_ff      <= '0;
         chained_ff        <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_HUE_KNOB:   knob_ff[CH_HUE]   <= KW'(csr_wdata);
            CSR_SAT_KNOB:   knob_ff[CH_SAT]   <= KW'(csr_wdata);
            CSR_LIGHT_KNOB: knob_ff[CH_LIGHT] <= KW'(csr_wdata);
            CSR_ALPHA_KNOB: knob_ff[CH_ALPHA] <= KW'(csr_wdata);
            CSR_CONNECTED:  connected_ff      <= csr_wdata[MASK_W-1:0];
            CSR_CHAINED:    chained_ff        <= csr_wdata[MASK_W-1:0];
            default: ;
         endcase
      end
   end

   // Input sample capture.
   logic signed [VOLTS_W-1:0] volts_ff [CHANNELS];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int i = 0; i < CHANNELS; i++) begin
            volts_ff[i] <= req_data[i * VOLTS_W +: VOLTS_W];
         end
      end
   end

   // Channel front end: flag update, offset, and setup of the divide by ten.
   logic signed [VOLTS_W-1:0] raw_v;
   logic                      conn_m, chain_m, flag_new, sub_five;
   logic [VADJ_W-1:0]         v_adj;
   logic [NW-1:0]             v_ext, n_val;
   logic [MW-1:0]             m_val;
   logic [XW-1:0]             x_val;
   logic [MASK_W-1:0]         flags_ff, flags_in;
   logic [XW-1:0]             x_ff;

   always_comb begin
      raw_v   = volts_ff[cmd.mul_idx];
      conn_m  = connected_ff[cmd.mul_idx];
      chain_m = chained_ff[cmd.mul_idx];
      if (raw_v < 0) begin
         flag_new = 1'b0;
      end else if (raw_v > FIVE_V) begin
         flag_new = 1'b1;
      end else begin
         flag_new = flags_ff[cmd.mul_idx];
      end
      sub_five = !chain_m && flag_new;
      v_adj    = {raw_v[VOLTS_W-1], raw_v} - (sub_five ? VADJ_W'(FIVE_VOLTS) : '0);
      v_ext    = {{(NW - VADJ_W){v_adj[VADJ_W-1]}}, v_adj};
      // Rounded tenth: floor((v * ONE + 5 V) / (5 * 2^13)); the shift floors first.
      n_val    = (v_ext << FRAC_BITS) + NW'(FIVE_VOLTS);
      m_val    = n_val[NW-1:DIV_SHIFT];
      // Bias by a multiple of five so the reciprocal multiply sees a positive value.
      x_val    = {{(XW - MW){m_val[MW-1]}}, m_val} + BIAS;

      flags_in = flags_ff;
      if (cmd.mul_op == MUL_TENTH && conn_m && !chain_m) begin
         flags_in[cmd.mul_idx] = flag_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_op == MUL_TENTH) begin
         x_ff <= x_val;
      end
   end

   // Color ramp operand selection.
   logic [PW-1:0]   pos_ff [3];
   logic [OW-1:0]   m1_ff, m2_ff;
   logic [PW-1:0]   xp;
   logic [OW-1:0]   frac_val, d_val;
   logic [1:0]      kind_in, kind_ff;

   always_comb begin
      xp    = pos_ff[cmd.mul_idx];
      d_val = m2_ff - m1_ff;
      if (xp < ONE_P) begin
         frac_val = xp[OW-1:0];
         kind_in  = KIND_RAMP;
      end else if (xp < THREE_P) begin
         frac_val = '0;
         kind_in  = KIND_HIGH;
      end else if (xp < FOUR_P) begin
         frac_val = OW'(FOUR_P - xp);
         kind_in  = KIND_RAMP;
      end else begin
         frac_val = '0;
         kind_in  = KIND_LOW;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_op == MUL_RAMP) begin
         kind_ff <= kind_in;
      end
   end

   // Shared multiplier, registered.
   logic [OW-1:0]  level_ff [CHANNELS];
   logic [XW-1:0]  mul_a, mul_b;
   logic [PRW-1:0] prod_ff, prod_ph;

   always_comb begin
      case (cmd.mul_op)
         MUL_TENTH: begin
            mul_a = x_val;
            mul_b = RECIP;
         end
         MUL_LS: begin
            mul_a = XW'(level_ff[CH_LIGHT]);
            mul_b = XW'(level_ff[CH_SAT]);
         end
         MUL_RAMP: begin
            mul_a = XW'(d_val);
            mul_b = XW'(frac_val);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   assign prod_ph = prod_ff + PRW'(HALF);

   // Channel back end: quotient correction, knob sum, hue wrap, clamp.
   logic [XW-1:0]        q_est, five_q, rem, q_val;
   logic signed [XW-1:0] t_val;
   logic signed [SW-1:0] t_ext, knob_ext, sum_raw, sum_w;
   logic [KW-1:0]        knob_sel;
   logic [OW-1:0]        knob_c, level_in;

   always_comb begin
      q_est    = prod_ff[PRW-1:XW];
      five_q   = (q_est << 2) + q_est;
      rem      = x_ff - five_q;
      q_val    = q_est + XW'(rem >= XW'(DIV_ODD));
      t_val    = q_val - QBIAS;
      t_ext    = {t_val[XW-1], t_val};
      knob_sel = knob_ff[cmd.fix_idx];
      knob_c   = (knob_sel > KW'(ONE)) ? ONE : knob_sel[OW-1:0];
      knob_ext = {{(SW - OW){1'b0}}, knob_c};
      sum_raw  = knob_ext + t_ext;
      sum_w    = sum_raw;
      if (cmd.fix_idx == CH_HUE) begin
         if (sum_raw < 0) begin
            sum_w = sum_raw + ONE_S;
         end else if (sum_raw > ONE_S) begin
            sum_w = sum_raw - ONE_S;
         end
      end
      if (!connected_ff[cmd.fix_idx]) begin
         level_in = knob_c;
      end else if (chained_ff[cmd.fix_idx]) begin
         level_in = clamp_one(t_ext);
      end else begin
         level_in = clamp_one(sum_w);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fix_en) begin
         level_ff[cmd.fix_idx] <= level_in;
      end
   end

   // Mix: lightness and saturation to the two ramp levels, hue to positions.
   logic [OW-1:0]        fls, lv, sv, m2_c, m1_c, m1_v, hv;
   logic signed [SW-1:0] l_s, s_s, fls_s, m2_raw, m1_raw;
   logic [PW-1:0]        h6_raw, h6, red_p, blue_p;

   always_comb begin
      fls    = prod_ph[FRAC_BITS + OW - 1:FRAC_BITS];
      lv     = level_ff[CH_LIGHT];
      sv     = level_ff[CH_SAT];
      l_s    = {{(SW - OW){1'b0}}, lv};
      s_s    = {{(SW - OW){1'b0}}, sv};
      fls_s  = {{(SW - OW){1'b0}}, fls};
      if (lv <= HALF) begin
         m2_raw = l_s + fls_s;
      end else begin
         m2_raw = l_s + s_s - fls_s;
      end
      m2_c   = clamp_one(m2_raw);
      m1_raw = (l_s <<< 1) - {{(SW - OW){1'b0}}, m2_c};
      m1_c   = clamp_one(m1_raw);
      m1_v   = (m1_c > m2_c) ? m2_c : m1_c;

      hv     = level_ff[CH_HUE];
      h6_raw = (PW'(hv) << 2) + (PW'(hv) << 1);
      h6     = (h6_raw >= SIX_P) ? h6_raw - SIX_P : h6_raw;
      red_p  = h6 + TWO_P;
      if (red_p >= SIX_P) begin
         red_p = red_p - SIX_P;
      end
      blue_p = (h6 < TWO_P) ? h6 + FOUR_P : h6 - TWO_P;
   end

   always_ff @(posedge clock) begin
      if (cmd.mix_en) begin
         m1_ff     <= m1_v;
         m2_ff     <= m2_c;
         pos_ff[0] <= red_p;
         pos_ff[1] <= h6;
         pos_ff[2] <= blue_p;
      end
   end

   // Ramp finish: one color per step.
   logic [OW-1:0] fm, color_in;
   logic [OW:0]   ramp_sum;
   logic [OW-1:0] color_ff [3];

   always_comb begin
      fm       = prod_ph[FRAC_BITS + OW - 1:FRAC_BITS];
      ramp_sum = {1'b0, m1_ff} + {1'b0, fm};
      case (kind_ff)
         KIND_RAMP: color_in = (ramp_sum > {1'b0, ONE}) ? ONE : ramp_sum[OW-1:0];
         KIND_HIGH: color_in = m2_ff;
         default:   color_in = m1_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.ramp_en) begin
         color_ff[cmd.ramp_idx] <= color_in;
      end
   end

   // Result register; holds while the consumer stalls.
   logic [RSP_W-1:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff <= RSP_W'({level_ff[CH_ALPHA], level_ff[CH_LIGHT], level_ff[CH_SAT],
                                level_ff[CH_HUE], color_ff[2], color_ff[1], color_ff[0]});
      end
   end

   assign rsp_data = rsp_data_ff;

   a_levels_ordered: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.mix_en) |-> m1_ff <= m2_ff)
      else $error("low ramp level exceeds high ramp level");

   a_color_in_range: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.ramp_en) |-> color_ff[$past(cmd.ramp_idx)] <= ONE)
      else $error("color component above full scale");

   a_level_in_range: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.fix_en) |-> level_ff[$past(cmd.fix_idx)] <= ONE)
      else $error("channel level above full scale");

   a_flags_only_on_divide: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_op != MUL_TENTH |=> flags_ff == $past(flags_ff))
      else $error("unipolar flags changed outside a channel divide step");

endmodule

// ===== rtl/hsla_modulate_to_rgb.sv =====
// A request transaction is accepted only while idle. Its response transaction is
// offered once the color phase is through and any earlier response is taken,
// and the next request is accepted only after that response is loaded. The
// steps come from the shared multiplier: four channel divides, one product of
// lightness and saturation and three color ramps, each a registered multiply.
// Reset (synchronous, active high) clears the sequencer, result valid and the
// unipolar flags and restores register defaults (alpha knob at full scale).
module hsla_modulate_to_rgb #(
   parameter int FRAC_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   // Request channel.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // From bit 0: hue_volts[16:0], sat_volts[33:17], light_volts[50:34],
   // alpha_volts[67:51], zero fill [71:68]. All fields signed, 1/4096 V.
   input  logic [hsla_pkg::REQ_DATA_W-1:0]    req_tdata,
   // Response channel.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // From bit 0, each FRAC_BITS+1 wide: red_level, green_level, blue_level,
   // hue_level, sat_level, light_level, alpha_level, then zero fill to bytes.
   output logic [((hsla_pkg::OUT_FIELDS * (FRAC_BITS + 1) + 7) / 8) * 8 - 1:0] rsp_tdata,
   // Configuration write port.
   input  logic                               csr_wr_en,
   input  logic [hsla_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [hsla_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import hsla_pkg::*;

   // The controller walks each transaction through three phases. In the channel
   // phase every channel is divided by ten through a reciprocal multiply and then
   // corrected, combined with its knob (chained: no knob; unconnected: knob only)
   // and clamped; the correction of one channel overlaps the multiply of the next.
   // The mix phase forms two ramp levels from lightness and saturation and the three
   // hue positions. The color phase runs the piecewise ramp for red, green and blue.
   hsla_cmd_type cmd;

   hsla_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // The datapath holds the configuration registers, so writes land there
   // directly; they are expected only while no transaction is in flight.
   hsla_dpath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_tdata),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_data  (rsp_tdata)
   );

endmodule
